// ----- src/ufbp_pkg.sv -----
// Shared types and constants for the UART frame bit packer.
// No dependencies; the encoder, result buffer and top level import this package.
`default_nettype none

package ufbp_pkg;

  localparam int unsigned OctetW   = 8;
  localparam int unsigned PendW    = 7;   // at most seven bits ever wait for the next octet
  localparam int unsigned PendCntW = 3;

  localparam logic [6:0] SyncTailBits   = 7'b000_1001;
  localparam logic [2:0] SyncTailLen    = 3'd4;
  localparam logic [7:0] EmptyFrameOctet = 8'h9F;

  // Bits of the line stream not yet packed into an octet, right-aligned.
  typedef struct packed {
    logic [PendW-1:0]    pend_bits;
    logic [PendCntW-1:0] pend_count;
    logic                started;
  } state_t;

  // One or two result octets produced by one input item.
  typedef struct packed {
    logic              two;
    logic [OctetW-1:0] octet0;
    logic              end0;
    logic [OctetW-1:0] octet1;
    logic              end1;
  } res_pair_t;

endpackage

`default_nettype wire

// ----- src/ufbp_if.sv -----
// Valid/ready channel interfaces for the UART frame bit packer.
// Standalone; used by the top level and the result buffer.
`default_nettype none

interface ufbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       empty_frame;

  modport source (output valid, output data_byte, output last_byte, output empty_frame,
                  input ready);
  modport sink (input valid, input data_byte, input last_byte, input empty_frame,
                output ready);
endinterface

interface ufbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- src/ufbp_encoder.sv -----
// Combinational framing of one byte onto the pending bit stream.
// Depends on ufbp_pkg.
`default_nettype none

module ufbp_encoder import ufbp_pkg::*; (
  input  state_t      cur,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        empty_frame,
  output res_pair_t   pair,
  output state_t      nxt
);

  logic [7:0]  rev;
  logic [6:0]  prefix;
  logic [2:0]  prefix_len;
  logic [9:0]  ten;
  logic [16:0] acc;
  logic [4:0]  total;
  logic [4:0]  sh0;
  logic [4:0]  sh1;
  logic        two;
  logic [2:0]  rem_len;
  logic [6:0]  rem;
  logic [15:0] pad_word;
  logic [7:0]  oct0;
  logic [7:0]  oct1;
  logic [7:0]  pad;

  // Data goes out LSB first, so it lands reversed in the MSB-first stream.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      rev[7-k] = data_byte[k];
    end
  end

  always_comb begin
    prefix_len = cur.started ? cur.pend_count : SyncTailLen;
    prefix     = cur.started ? (cur.pend_bits & ~(7'h7F << cur.pend_count)) : SyncTailBits;
    ten        = {1'b0, rev, 1'b1};
    acc        = {prefix, 10'b0} | {7'b0, ten};
    total      = 5'(prefix_len) + 5'd10;
    sh0        = total - 5'd8;
    sh1        = total - 5'd16;
    two        = (total >= 5'd16);
    oct0       = 8'(acc >> sh0);
    oct1       = 8'(acc >> sh1);
    rem_len    = two ? sh1[2:0] : sh0[2:0];
    rem        = acc[6:0] & ~(7'h7F << rem_len);
    pad_word   = {1'b0, rem, 8'hFF} >> rem_len;
    pad        = pad_word[7:0];
  end

  always_comb begin
    pair.two    = two;
    pair.octet0 = oct0;
    pair.end0   = 1'b0;
    pair.octet1 = oct1;
    pair.end1   = 1'b0;
    nxt.pend_bits  = rem;
    nxt.pend_count = rem_len;
    nxt.started    = 1'b1;

    if (empty_frame) begin
      pair.two    = 1'b0;
      pair.octet0 = EmptyFrameOctet;
      pair.end0   = 1'b1;
      nxt         = '0;
    end else if (last_byte) begin
      nxt = '0;
      if (two) begin
        // Second octet closes the frame; any leftover bit cannot fit.
        pair.end1 = 1'b1;
      end else if (rem_len != 3'd0) begin
        pair.two    = 1'b1;
        pair.octet1 = pad;
        pair.end1   = 1'b1;
      end else begin
        pair.end0 = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/ufbp_result_buf.sv -----
// Two-slot result buffer that drains one octet per transfer.
// Depends on ufbp_pkg and ufbp_if.
`default_nettype none

module ufbp_result_buf import ufbp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  res_pair_t         pair,
  output logic              free,
  ufbp_out_if.source        result
);

  logic [1:0] cnt;
  logic [7:0] octet0;
  logic [7:0] octet1;
  logic       end0;
  logic       end1;
  logic       pop;

  assign pop  = result.valid && result.ready;
  assign free = (cnt == 2'd0) || ((cnt == 2'd1) && pop);

  assign result.valid     = (cnt != 2'd0);
  assign result.out_byte  = octet0;
  assign result.frame_end = end0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= pair.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      octet0 <= pair.octet0;
      end0   <= pair.end0;
      octet1 <= pair.octet1;
      end1   <= pair.end1;
    end else if (pop) begin
      octet0 <= octet1;
      end0   <= end1;
    end
  end

endmodule

`default_nettype wire

// ----- src/uart_frame_bit_packer_unit.sv -----
// Top level of the UART frame bit packer: input register, pending-bit state, result buffer.
// Depends on ufbp_pkg, ufbp_if, ufbp_encoder and ufbp_result_buf.
`default_nettype none

// Frames the bytes of one radio frame as a UART 8N1 line stream, MSB first,
// opened by the sync tail 1001, and hands it out as whole octets. Each byte
// becomes a 0 start bit, eight data bits LSB first and a 1 stop bit; full
// octets go out as soon as they fill, and the byte marked last_byte pads the
// remaining bits with ones into one more octet (or drops a leftover bit if it
// already fills two) and flags the closing octet with frame_end. An item with
// empty_frame set drops any open frame and yields the single octet 0x9F. An
// accepted item is held in the input register, framed in one pass of
// combinational logic and loaded into a two-slot result buffer once it has
// room; the buffer offers its first octet on the result channel, gives out
// one octet per transfer and loads the next item as the last octet of the one
// before is taken. While the result channel stalls, the input register still
// takes one more transfer and holds it; item.ready then stays low until the
// buffer has room, and with one octet left it follows result.ready in the same cycle.
module uart_frame_bit_packer_unit import ufbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ufbp_in_if.sink    item,
  ufbp_out_if.source result
);

  // Input register
  logic       in_valid;
  logic [7:0] in_data;
  logic       in_last;
  logic       in_empty;

  // Pending line bits carried between bytes of a frame
  state_t     state;
  state_t     state_next;

  res_pair_t  pair;
  logic       free;
  logic       load;

  // Move the held item into the buffer as soon as it has room for it.
  assign load       = in_valid && free;
  assign item.ready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  // Capture payload on each input transfer; no reset needed.
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_data  <= item.data_byte;
      in_last  <= item.last_byte;
      in_empty <= item.empty_frame;
    end
  end

  // Advance the frame state only when the item's octets are taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (load) begin
      state <= state_next;
    end
  end

  ufbp_encoder u_encoder (
    .cur         (state),
    .data_byte   (in_data),
    .last_byte   (in_last),
    .empty_frame (in_empty),
    .pair        (pair),
    .nxt         (state_next)
  );

  ufbp_result_buf u_result_buf (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .pair   (pair),
    .free   (free),
    .result (result)
  );

endmodule

`default_nettype wire
